/* rtl/core/prma_pkg.sv */
// ----------------------------------------------------------------------------
// prma_pkg
// Types, constants and helpers shared by the pixel running mean accumulator.
// ----------------------------------------------------------------------------
package prma_pkg;

  localparam int unsigned MaxWidth    = 256;
  localparam int unsigned MaxHeight   = 256;
  localparam int unsigned ChannelBits = 16;
  localparam int unsigned FracBits    = ChannelBits - 4;
  localparam int unsigned CountBits   = 16;
  localparam int unsigned ColBits     = $clog2(MaxWidth);
  localparam int unsigned RowBits     = $clog2(MaxHeight);
  localparam int unsigned AddrBits    = ColBits + RowBits;
  localparam int unsigned Pixels      = MaxWidth * MaxHeight;
  localparam int unsigned WordBits    = 3 * ChannelBits + CountBits;
  localparam int unsigned DimBits     = 9;
  localparam int unsigned FifoDepth   = 2;
  localparam int unsigned CfgIdxBits  = 2;

  localparam logic [CfgIdxBits-1:0] CfgWidth  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgHeight = 2'd1;

  localparam logic [2:0] ReqSet     = 3'd0;
  localparam logic [2:0] ReqAccXy   = 3'd1;
  localparam logic [2:0] ReqAccScan = 3'd2;
  localparam logic [2:0] ReqRead    = 3'd3;
  localparam logic [2:0] ReqClear   = 3'd4;
  localparam logic [2:0] ReqRestart = 3'd5;

  typedef enum logic [2:0] {
    OP_SET,
    OP_ACC,
    OP_READ,
    OP_CLEAR,
    OP_IGNORE
  } op_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] in_red;
    logic [15:0] in_green;
    logic [15:0] in_blue;
  } req_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] sample_count;
    logic [23:0] packed_rgb;
    logic [7:0]  scan_col;
    logic [8:0]  scan_row;
    logic        frame_full;
    logic        ignored;
  } res_t;

  // one queued command: colour is {blue, green, red}
  typedef struct packed {
    op_e                        op;
    logic [AddrBits-1:0]        addr;
    logic [3*ChannelBits-1:0]   color;
    logic [7:0]                 scan_col;
    logic [8:0]                 scan_row;
    logic                       full;
  } cmd_t;

  function automatic logic [7:0] to_byte(input logic [ChannelBits-1:0] v);
    logic [ChannelBits+7:0] prod;
    logic [ChannelBits+7-FracBits:0] sh;
    prod = ({8'd0, v} << 8) - {8'd0, v};
    sh   = prod[ChannelBits+7:FracBits];
    to_byte = (sh > 255) ? 8'hFF : sh[7:0];
  endfunction

endpackage

/* rtl/core/prma_ram.sv */
// ----------------------------------------------------------------------------
// prma_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module prma_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/prma_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// prma_cmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module prma_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  prma_pkg::cmd_t push_data_i,
  input  logic          pop_i,
  output prma_pkg::cmd_t head_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrBits = $clog2(prma_pkg::FifoDepth);

  prma_pkg::cmd_t mem_q [prma_pkg::FifoDepth];
  logic [PtrBits-1:0] wptr_q, rptr_q;
  logic [PtrBits:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrBits+1)'(prma_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrBits'(prma_pkg::FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrBits'(prma_pkg::FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/prma_front.sv */
// ----------------------------------------------------------------------------
// prma_front
// Accepts requests, keeps configuration and scan position, and turns each
// request into a queued store command.
// ----------------------------------------------------------------------------
module prma_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  prma_pkg::req_t                      req_i,
  input  logic                                cfg_we_i,
  input  logic [prma_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [prma_pkg::DimBits-1:0]        cfg_data_i,
  output logic                                push_o,
  output prma_pkg::cmd_t                      cmd_o
);

  localparam logic [prma_pkg::DimBits-1:0] MaxW = prma_pkg::DimBits'(prma_pkg::MaxWidth);
  localparam logic [prma_pkg::DimBits-1:0] MaxH = prma_pkg::DimBits'(prma_pkg::MaxHeight);

  logic [prma_pkg::DimBits-1:0] width_q, height_q, eff_w, eff_h;
  logic [7:0] col_q, col_d;
  logic [8:0] row_q, row_d;
  logic       full_now, full_after;
  logic [8:0] col_inc;

  assign eff_w = (width_q == '0) ? 9'd1 : ((width_q > MaxW) ? MaxW : width_q);
  assign eff_h = (height_q == '0) ? 9'd1 : ((height_q > MaxH) ? MaxH : height_q);
  assign full_now = (row_q >= eff_h);
  assign col_inc  = {1'b0, col_q} + 9'd1;

  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    cmd_o.op     = prma_pkg::OP_READ;
    cmd_o.addr   = {req_i.pixel_y, req_i.pixel_x};
    cmd_o.color  = {req_i.in_blue, req_i.in_green, req_i.in_red};
    unique case (req_i.req_type)
      prma_pkg::ReqSet:   cmd_o.op = prma_pkg::OP_SET;
      prma_pkg::ReqAccXy: cmd_o.op = prma_pkg::OP_ACC;
      prma_pkg::ReqAccScan: begin
        if (full_now) begin
          cmd_o.op = prma_pkg::OP_IGNORE;
        end else begin
          cmd_o.op   = prma_pkg::OP_ACC;
          cmd_o.addr = {row_q[7:0], col_q};
          if (col_inc >= eff_w) begin
            col_d = '0;
            row_d = row_q + 9'd1;
          end else begin
            col_d = col_inc[7:0];
          end
        end
      end
      prma_pkg::ReqClear: cmd_o.op = prma_pkg::OP_CLEAR;
      prma_pkg::ReqRestart: begin
        col_d = '0;
        row_d = '0;
      end
      default: cmd_o.op = prma_pkg::OP_READ;
    endcase
    full_after     = (row_d >= eff_h);
    cmd_o.scan_col = col_d;
    cmd_o.scan_row = row_d;
    cmd_o.full     = full_after;
  end

  assign push_o = accept_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= MaxW;
      height_q <= MaxH;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == prma_pkg::CfgWidth) begin
        width_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == prma_pkg::CfgHeight) begin
        height_q <= cfg_data_i;
      end
      if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

endmodule

/* rtl/core/prma_back.sv */
// ----------------------------------------------------------------------------
// prma_back
// Executes queued commands against the frame store: read-modify-write with
// an iterative divider for the running mean, and store sweeps for clear.
// ----------------------------------------------------------------------------
module prma_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  prma_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           init_o,
  output logic           res_valid_o,
  output prma_pkg::res_t res_o
);

  localparam int unsigned CB = prma_pkg::ChannelBits;
  localparam int unsigned AB = prma_pkg::AddrBits;
  localparam int unsigned NB = prma_pkg::CountBits;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_WRITE,
    ST_SWEEP
  } state_e;

  state_e state_q;
  logic   init_q;
  prma_pkg::cmd_t cmd_q;
  logic [AB-1:0]  sweep_q;
  logic [NB-1:0]  n_q;
  logic [2*CB-1:0] prod_q [3];
  logic [CB-1:0]  rem_q [3];
  logic [CB-1:0]  quo_q [3];
  logic [4:0]     cnt_q;
  logic           res_valid_q;
  prma_pkg::res_t res_q;

  logic                          we;
  logic [AB-1:0]                 waddr;
  logic [prma_pkg::WordBits-1:0] wdata, rdata;
  logic [NB:0]                   divisor;
  logic [CB-1:0]                 rem_d [3];
  logic [CB-1:0]                 quo_d [3];
  logic [NB-1:0]                 n_next;
  logic [3*CB-1:0]               quo_color;

  function automatic prma_pkg::res_t make_res(input logic [3*CB-1:0] color,
                                              input logic [NB-1:0] count,
                                              input prma_pkg::cmd_t cmd);
    prma_pkg::res_t r;
    r.out_red      = color[CB-1:0];
    r.out_green    = color[2*CB-1:CB];
    r.out_blue     = color[3*CB-1:2*CB];
    r.sample_count = count;
    r.packed_rgb   = {prma_pkg::to_byte(color[CB-1:0]),
                      prma_pkg::to_byte(color[2*CB-1:CB]),
                      prma_pkg::to_byte(color[3*CB-1:2*CB])};
    r.scan_col     = cmd.scan_col;
    r.scan_row     = cmd.scan_row;
    r.frame_full   = cmd.full;
    r.ignored      = 1'b0;
    make_res = r;
  endfunction

  // refused scan accumulate: pixel fields stay zero
  function automatic prma_pkg::res_t make_ign(input prma_pkg::cmd_t cmd);
    prma_pkg::res_t r;
    r            = '0;
    r.scan_col   = cmd.scan_col;
    r.scan_row   = cmd.scan_row;
    r.frame_full = cmd.full;
    r.ignored    = 1'b1;
    make_ign = r;
  endfunction

  prma_ram #(
    .Width (prma_pkg::WordBits),
    .Depth (prma_pkg::Pixels)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (head_i.addr),
    .rdata_o (rdata)
  );

  assign divisor   = {1'b0, n_q} + 1'b1;
  assign n_next    = (n_q == '1) ? n_q : n_q + 1'b1;
  assign quo_color = {quo_q[2], quo_q[1], quo_q[0]};

  // one restoring division step per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [CB:0] t;
      t = {rem_q[c], quo_q[c][CB-1]};
      if (t >= divisor) begin
        rem_d[c] = CB'(t - divisor);
        quo_d[c] = {quo_q[c][CB-2:0], 1'b1};
      end else begin
        rem_d[c] = t[CB-1:0];
        quo_d[c] = {quo_q[c][CB-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cmd_q.addr;
    wdata = {n_next, quo_color};
    pop_o = (state_q == ST_IDLE) && !empty_i;
    unique case (state_q)
      ST_SWEEP: begin
        we    = 1'b1;
        waddr = sweep_q;
        wdata = {{NB{1'b0}}, (init_q ? {3*CB{1'b0}} : cmd_q.color)};
      end
      ST_READ: begin
        if (cmd_q.op == prma_pkg::OP_SET) begin
          we    = 1'b1;
          wdata = {NB'(1), cmd_q.color};
        end
      end
      ST_WRITE: we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          cmd_q <= head_i;
        end
      end
      ST_READ: begin
        n_q <= rdata[prma_pkg::WordBits-1:3*CB];
        for (int c = 0; c < 3; c++) begin
          prod_q[c] <= rdata[c*CB +: CB] * rdata[prma_pkg::WordBits-1:3*CB];
        end
      end
      ST_MUL: begin
        for (int c = 0; c < 3; c++) begin
          logic [2*CB-1:0] num;
          num = prod_q[c] + {{CB{1'b0}}, cmd_q.color[c*CB +: CB]};
          rem_q[c] <= num[2*CB-1:CB];
          quo_q[c] <= num[CB-1:0];
        end
        cnt_q <= 5'(CB);
      end
      ST_DIV: begin
        for (int c = 0; c < 3; c++) begin
          rem_q[c] <= rem_d[c];
          quo_q[c] <= quo_d[c];
        end
        cnt_q <= cnt_q - 1'b1;
      end
      default: begin
      end
    endcase
    if (state_q == ST_READ && cmd_q.op == prma_pkg::OP_READ) begin
      res_q <= make_res(rdata[3*CB-1:0], rdata[prma_pkg::WordBits-1:3*CB], cmd_q);
    end else if (state_q == ST_READ) begin
      res_q <= make_res(cmd_q.color, NB'(1), cmd_q);
    end else if (state_q == ST_WRITE) begin
      res_q <= make_res(quo_color, n_next, cmd_q);
    end else if (state_q == ST_SWEEP) begin
      res_q <= make_res(cmd_q.color, '0, cmd_q);
    end else if (state_q == ST_IDLE) begin
      res_q <= make_ign(head_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      init_q      <= 1'b1;
      sweep_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            unique case (head_i.op)
              prma_pkg::OP_CLEAR: begin
                sweep_q <= '0;
                state_q <= ST_SWEEP;
              end
              prma_pkg::OP_IGNORE: res_valid_q <= 1'b1;
              default: state_q <= ST_READ;
            endcase
          end
        end
        ST_READ: begin
          if (cmd_q.op == prma_pkg::OP_ACC) begin
            state_q <= ST_MUL;
          end else begin
            res_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_MUL: state_q <= ST_DIV;
        ST_DIV: begin
          if (cnt_q == 5'd1) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          res_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        ST_SWEEP: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == '1) begin
            state_q <= ST_IDLE;
            init_q  <= 1'b0;
            if (!init_q) begin
              res_valid_q <= 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign init_o      = init_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/core/pixel_running_mean_accumulator.sv */
// ----------------------------------------------------------------------------
// pixel_running_mean_accumulator
// Frame store of RGB running means with per-pixel sample counts.
// ----------------------------------------------------------------------------
// Accumulate runs through the 16-step restoring divider, one per channel.
// Clear sweeps the store one entry per cycle.
// The back end works on one command at a time; a two-entry queue absorbs
// requests meanwhile.
// Reset: a pass over all 65536 entries zeroes the store, busy held high.
// Results are a one-cycle strobe; the receiver cannot stall.
module pixel_running_mean_accumulator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  prma_pkg::req_t                  req_i,
  output logic                            res_valid_o,
  output prma_pkg::res_t                  res_o,
  input  logic                            cfg_we_i,
  input  logic [prma_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [prma_pkg::DimBits-1:0]    cfg_data_i
);

  logic           accept, push, pop, full, empty, init;
  prma_pkg::cmd_t cmd, head;

  assign busy   = full | init;
  assign accept = start & ~busy;

  prma_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  prma_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  prma_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .init_o      (init),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
